// ===== hdl/insertion_sort_engine_defines.svh =====
// Assertion macros for the insertion sort engine.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef INSERTION_SORT_ENGINE_DEFINES_SVH
`define INSERTION_SORT_ENGINE_DEFINES_SVH

// same-cycle implication
`define ISE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("insertion_sort_engine: same-cycle check failed");

// next-cycle implication
`define ISE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("insertion_sort_engine: next-cycle check failed");

`endif

// ===== hdl/isrt_pkg.sv =====
// Shared constants and controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isrt_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic load_item;   // capture input transaction
        logic rd_prev;     // read entry below insert point
        logic shift;       // move read entry up one slot
        logic ins_write;   // write new value at insert point
        logic emit_start;  // reset output index
        logic emit_rd;     // read entry at output index
        logic emit_ld;     // load output register
        logic clear_set;   // drop count and overflow flag
    } isrt_cmd_t;

    typedef struct packed {
        logic store_full;
        logic idx_zero;
        logic less;
        logic set_last;
        logic count_ge2;
        logic emit_last;
        logic out_free;
    } isrt_status_t;

endpackage

`default_nettype wire

// ===== hdl/isrt_if.sv =====
// Valid/ready stream interfaces for input and result transactions.
// Depends on isrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface isrt_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [isrt_pkg::DATA_W-1:0]    value;
    logic                                  last;

    modport source (output valid, value, last, input ready);
    modport sink   (input valid, value, last, output ready);
endinterface

interface isrt_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [isrt_pkg::DATA_W-1:0]    sorted_value;
    logic                                  end_of_run;
    logic                                  overflowed;

    modport source (output valid, sorted_value, end_of_run, overflowed, input ready);
    modport sink   (input valid, sorted_value, end_of_run, overflowed, output ready);
endinterface

`default_nettype wire

// ===== hdl/isrt_ctrl.sv =====
// Controller: sequences insertion of each transaction and emission of a sorted set.
// Depends on isrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isrt_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire isrt_pkg::isrt_status_t status,
    output isrt_pkg::isrt_cmd_t         cmd
);
    import isrt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DECIDE,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = status.store_full ? S_DECIDE : S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                if (status.idx_zero)
                begin
                    cmd.ins_write = 1'b1;
                    state_next    = S_DECIDE;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (status.less)
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    cmd.ins_write = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!status.set_last)
                    state_next = S_IDLE;
                else if (status.count_ge2)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_EMIT_RD;
                end
                else
                begin
                    cmd.clear_set = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = S_EMIT_LD;
                end
            end
            S_EMIT_LD:
            begin
                cmd.emit_ld = 1'b1;
                if (status.emit_last)
                begin
                    cmd.clear_set = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                    state_next = S_EMIT_RD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== hdl/isrt_datapath.sv =====
// Datapath: value store, set count, overflow flag, insert compare and output register.
// Depends on isrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isrt_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [isrt_pkg::DATA_W-1:0] in_value,
    input  wire logic                          in_last,
    input  wire isrt_pkg::isrt_cmd_t           cmd,
    output isrt_pkg::isrt_status_t             status,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [isrt_pkg::DATA_W-1:0] out_value,
    output logic                               out_end,
    output logic                               out_ovf
);
    import isrt_pkg::*;

    logic [DATA_W-1:0]         mem [0:MAX_ITEMS-1];
    logic [COUNT_W-1:0]        count_reg;
    logic                      ovf_reg;
    logic signed [DATA_W-1:0]  val_reg;
    logic                      last_reg;
    logic [COUNT_W-1:0]        idx_reg;
    logic [DATA_W-1:0]         rd_data_reg;
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  out_value_reg;
    logic                      out_end_reg;
    logic                      out_ovf_reg;

    logic [COUNT_W-1:0]        idx_prev;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [DATA_W-1:0]         wr_data;

    assign idx_prev = idx_reg - COUNT_W'(1);
    assign rd_en    = cmd.rd_prev | cmd.emit_rd;
    assign rd_addr  = cmd.rd_prev ? idx_prev[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign wr_en    = cmd.shift | cmd.ins_write;
    assign wr_data  = cmd.shift ? rd_data_reg : val_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[idx_reg[ADDR_W-1:0]] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        status.store_full = (count_reg == COUNT_W'(MAX_ITEMS));
        status.idx_zero   = (idx_reg == '0);
        status.less       = (val_reg < $signed(rd_data_reg));
        status.set_last   = last_reg;
        status.count_ge2  = (count_reg >= COUNT_W'(2));
        status.emit_last  = (idx_reg == count_reg - COUNT_W'(1));
        status.out_free   = !out_valid_reg || out_ready;
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            val_reg  <= in_value;
            last_reg <= in_last;
            idx_reg  <= count_reg;
        end
        else if (cmd.shift)
            idx_reg <= idx_prev;
        else if (cmd.emit_start)
            idx_reg <= '0;
        else if (cmd.emit_ld)
            idx_reg <= idx_reg + COUNT_W'(1);

        if (cmd.emit_ld)
        begin
            out_value_reg <= $signed(rd_data_reg);
            out_end_reg   <= status.emit_last;
            out_ovf_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_set)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.ins_write)
                    count_reg <= count_reg + COUNT_W'(1);
                if (cmd.load_item && status.store_full)
                    ovf_reg <= 1'b1;
            end

            if (cmd.emit_ld)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_end   = out_end_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

`default_nettype wire

// ===== hdl/insertion_sort_engine.sv =====
// Top level of the insertion sort engine: controller, datapath and stream ports.
// Depends on isrt_pkg, isrt_if, isrt_ctrl, isrt_datapath, insertion_sort_engine_defines.svh.
//
//  Port     Dir   Transaction
//  in_ch    sink  value (signed 32), last
//  out_ch   src   sorted_value (signed 32), end_of_run, overflowed
//
// Each accepted value is inserted at once: every stored value larger than it
// moves up one slot, then the value is written into the freed slot; a value
// dropped by a full store only sets the overflow flag. After the final value
// of a set of two or more, results leave in order, each read only once the
// output register is free; a stalled output holds the sequence in place.
// in_ch.ready is high only while no value is inserted and no set is emitted.
// Reset is asynchronous and empties the set; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "insertion_sort_engine_defines.svh"

module insertion_sort_engine (
    input  wire logic   clk,
    input  wire logic   rst_n,
    isrt_in_if.sink     in_ch,
    isrt_out_if.source  out_ch
);
    import isrt_pkg::*;

    isrt_cmd_t    cmd;
    isrt_status_t status;
    logic [6:0]   cmd_pulses;

    isrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    isrt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_value  (in_ch.value),
        .in_last   (in_ch.last),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_value (out_ch.sorted_value),
        .out_end   (out_ch.end_of_run),
        .out_ovf   (out_ch.overflowed)
    );

    assign cmd_pulses = {cmd.load_item, cmd.rd_prev, cmd.shift, cmd.ins_write,
                         cmd.emit_start, cmd.emit_rd, cmd.emit_ld};

    `ISE_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
    `ISE_ASSERT_IMP(a_no_overwrite, cmd.emit_ld, !out_ch.valid)
    `ISE_ASSERT_IMP(a_cmd_exclusive, 1'b1, $onehot0(cmd_pulses))

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for insertion_sort_engine: directed table, then random sets.
// Depends on isrt_pkg, isrt_if and the insertion_sort_engine RTL.
// Expected sorted results come from an in-bench stable insertion model.
`timescale 1ns / 1ps

module testbench;
    import isrt_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     eor;
        logic                     ovf;
    } sort_result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     typed;
        sort_result_t             res;
    } dir_row_t;

    localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam int NUM_ROWS = 24;
    localparam int PHASE_ITEMS = 105;
    localparam int LONG_HOLD = 600;

    // typed rows carry the k-th sorted result of their set
    localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
        '{VMAX, 1'b0, 1'b1, '{VMIN, 1'b0, 1'b0}},
        '{VMIN, 1'b1, 1'b1, '{VMAX, 1'b1, 1'b0}},
        '{32'sd5, 1'b1, 1'b1, '{32'sd0, 1'b0, 1'b0}},
        '{32'sd0, 1'b0, 1'b1, '{-32'sd1, 1'b0, 1'b0}},
        '{-32'sd1, 1'b1, 1'b1, '{32'sd0, 1'b1, 1'b0}},
        '{32'sd3, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{-32'sd1, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{32'sd3, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{32'sd0, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{32'sd3, 1'b1, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{VMIN, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{VMAX, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{32'sd0, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{-32'sd1, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{32'sd1, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{32'sh5555_5555, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{32'shAAAA_AAAA, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{32'sd7, 1'b1, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{-32'sd7, 1'b0, 1'b1, '{-32'sd7, 1'b0, 1'b0}},
        '{-32'sd7, 1'b1, 1'b1, '{-32'sd7, 1'b1, 1'b0}},
        '{32'sd100, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{32'sd99, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{32'sd98, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
        '{32'sd97, 1'b1, 1'b0, '{32'sd0, 1'b0, 1'b0}}
    };

    logic clk;
    logic rst_n;

    isrt_in_if  in_ch ();
    isrt_out_if out_ch ();

    insertion_sort_engine i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // sorting model state
    logic signed [DATA_W-1:0] held_values [MAX_ITEMS];
    int                       held_count = 0;
    logic                     held_dropped = 1'b0;

    sort_result_t fresh_sorted [$];
    sort_result_t pending_sorted [$];
    logic         row_is_typed [$];
    sort_result_t typed_sorted [$];
    sort_result_t typed_for_set [$];

    int   fail_count = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    logic hold_request = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // stable insertion: a new value goes above every stored value not larger than it
    function automatic void sort_insert(input logic signed [DATA_W-1:0] v, input logic l);
        int pos;
        if (held_count < MAX_ITEMS)
        begin
            pos = held_count;
            while (pos > 0 && v < held_values[pos-1])
            begin
                held_values[pos] = held_values[pos-1];
                pos--;
            end
            held_values[pos] = v;
            held_count++;
        end
        else
            held_dropped = 1'b1;
        if (l)
        begin
            if (held_count >= 2)
                for (int k = 0; k < held_count; k++)
                    fresh_sorted.push_back('{held_values[k], k == held_count - 1, held_dropped});
            held_count = 0;
            held_dropped = 1'b0;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(7))
            0: return VMIN;
            1: return VMAX;
            2: return $urandom_range(8) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic int random_set_len();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return 1;
        else if (pick <= 15)
            return $urandom_range(2, 8);
        else if (pick <= 18)
            return $urandom_range(9, 20);
        else
            return $urandom_range(21, 40);
    endfunction

    task automatic send_item(input logic signed [DATA_W-1:0] v, input logic l);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= l;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_sorted.size() == 0);
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // transaction monitor and checker
    always @(posedge clk)
    begin
        sort_result_t got;
        sort_result_t want;
        logic         typed_now;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                typed_now = 1'b0;
                if (row_is_typed.size() > 0)
                    typed_now = row_is_typed.pop_front();
                if (typed_now)
                    typed_for_set.push_back(typed_sorted.pop_front());
                sort_insert(in_ch.value, in_ch.last);
                if (in_ch.last)
                begin
                    if (typed_now)
                    begin
                        if (fresh_sorted.size() > 0)
                            foreach (typed_for_set[k])
                                pending_sorted.push_back(typed_for_set[k]);
                        typed_for_set.delete();
                    end
                    else
                        foreach (fresh_sorted[k])
                            pending_sorted.push_back(fresh_sorted[k]);
                    fresh_sorted.delete();
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.sorted_value, out_ch.end_of_run, out_ch.overflowed};
                if (pending_sorted.size() == 0)
                begin
                    $error("sorted_value: unexpected transaction, got %0d", got.value);
                    fail_count++;
                end
                else
                begin
                    want = pending_sorted.pop_front();
                    if (got.value !== want.value)
                    begin
                        $error("sorted_value: expected %0d, got %0d", want.value, got.value);
                        fail_count++;
                    end
                    if (got.eor !== want.eor)
                    begin
                        $error("end_of_run: expected %0b, got %0b", want.eor, got.eor);
                        fail_count++;
                    end
                    if (got.ovf !== want.ovf)
                    begin
                        $error("overflowed: expected %0b, got %0b", want.ovf, got.ovf);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int ph_items;
        int num_sets;
        int len;
        int big_len;
        rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 15;
        stall_pct = 15;
        foreach (DIR_ROWS[r])
        begin
            row_is_typed.push_back(DIR_ROWS[r].typed);
            if (DIR_ROWS[r].typed)
                typed_sorted.push_back(DIR_ROWS[r].res);
        end
        foreach (DIR_ROWS[r])
            send_item(DIR_ROWS[r].value, DIR_ROWS[r].last);
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  big_len = 64; end
                1: begin idle_pct = 85; stall_pct = 0;  big_len = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; big_len = 65; end
                default: begin idle_pct = 15; stall_pct = 15; big_len = 67; end
            endcase
            ph_items = 0;
            num_sets = 0;
            while (ph_items < PHASE_ITEMS)
            begin
                len = random_set_len();
                if (num_sets == 0 && big_len > 0)
                    len = big_len;
                if (ph == 0 && num_sets == 1)
                begin
                    hold_request = 1'b1;
                    len = 30;
                end
                for (int i = 0; i < len; i++)
                    send_item(random_value(), i == len - 1);
                ph_items += len;
                num_sets++;
            end
            drain_results();
        end

        // a trailing single-value set may still be inserting
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending_sorted.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== insertion_sort_engine.f =====
+incdir+hdl
hdl/isrt_pkg.sv
hdl/isrt_if.sv
hdl/isrt_ctrl.sv
hdl/isrt_datapath.sv
hdl/insertion_sort_engine.sv
tb/testbench.sv
